@@ rtl/slpg_pkg.sv @@
// Package for the status LED pattern generator: payload types, mode codes and timing constants.
package slpg_pkg;

   // Mode codes; code seven is unused and a request for it is ignored.
   typedef enum logic [2:0] {
      MODE_OFF          = 3'd0,
      MODE_BOOT         = 3'd1,
      MODE_CONNECTING   = 3'd2,
      MODE_CONNECTED    = 3'd3,
      MODE_DISCONNECTED = 3'd4,
      MODE_ERROR        = 3'd5,
      MODE_UPDATE       = 3'd6
   } mode_type;

   // Input item kinds.
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_MODE = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_MAX_BRIGHTNESS = 1'b0;
   localparam logic CSR_ENABLE_PRESENT = 1'b1;

   // Register reset values.
   localparam logic [7:0] MAX_BRIGHTNESS_RESET = 8'd30;
   localparam logic       ENABLE_PRESENT_RESET = 1'b1;

   // Timing in one millisecond ticks.
   localparam logic [15:0] BOOT_HALF_MS    = 16'd500;
   localparam logic [15:0] ERROR_HALF_MS   = 16'd200;
   localparam logic [15:0] CONNECTED_MS    = 16'd1000;
   localparam logic [15:0] RAMP_REFRESH_MS = 16'd20;
   localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
   localparam logic [10:0] RAMP_PERIOD_MS  = 11'd2000;
   localparam logic [10:0] RAMP_HALF_MS    = 11'd1000;

   // Division by 1000 of the ramp product (below 2^18) as a reciprocal multiply.
   localparam int          RAMP_SHIFT = 28;
   localparam logic [18:0] RAMP_RECIP = 19'd268436;

   // Division by three of an 8-bit level: (x * 171) >> 9 is exact below 512.
   localparam logic [15:0] THIRD_RECIP = 16'd171;
   localparam int          THIRD_SHIFT = 9;

   // Input item.
   typedef struct packed {
      logic       kind;
      logic [2:0] new_mode;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       power_enable;
      logic       write_strobe;
   } rsp_type;

endpackage

@@ rtl/status_led_pattern_generator.sv @@
// Status LED pattern generator: mode machine, blink and ramp timing, and color output.
// A result passes through the middle stage and then the output register after its request transfer.
// Throughput: one item per cycle while rsp_ready does not stall the output; the mode machine updates
// in the cycle of the transfer and the ramp level is divided by 1000 in the output stage.
// Reset (synchronous, active high): mode off, counters zero, color black, enable low,
// brightness 30, enable present 1, both pipeline stages empty.
module status_led_pattern_generator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  slpg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output slpg_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [7:0]        csr_write_data
);

   // Contents of the middle stage.
   typedef struct packed {
      logic        wr;
      logic        ramp;
      logic [23:0] colour;
      logic [17:0] product;
      logic        power_enable;
   } s1_type;

   // Configuration registers.
   logic [7:0] max_brightness_ff;
   logic       enable_present_ff;

   // Mode machine state.
   slpg_pkg::mode_type mode_ff, mode_in;
   logic        lit_ff, lit_in;
   logic        enable_level_ff, enable_level_in;
   logic [15:0] since_toggle_ff, since_toggle_in;
   logic [15:0] mode_age_ff, mode_age_in;
   logic [10:0] phase_ff, phase_in;

   // Pipeline registers.
   logic              s1_valid_ff;
   s1_type            s1_ff, s1_in;
   logic              rsp_valid_ff;
   slpg_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Handshake and datapath signals.
   logic        req_fire;
   logic        s2_take;
   logic        s1_take;
   logic [15:0] st_inc;
   logic [15:0] age_inc;
   logic [10:0] phase_inc;
   logic [9:0]  tri_level;
   logic [17:0] ramp_product;
   logic [15:0] third_product;
   logic [7:0]  third;
   logic        en_set;
   logic        en_clr;
   logic [36:0] quot_full;
   logic [7:0]  ramp_level;

   // Flow control: the output register frees when taken, the middle stage when it moves on.
   assign s2_take   = !rsp_valid_ff || rsp_ready;
   assign s1_take   = !s1_valid_ff || s2_take;
   assign req_ready = s1_take;
   assign req_fire  = req_valid && s1_take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Saturating counters and the ramp phase, which tracks mode_age modulo the period.
   assign st_inc  = (since_toggle_ff == slpg_pkg::COUNT_MAX) ? since_toggle_ff
                                                             : since_toggle_ff + 16'd1;
   assign age_inc = (mode_age_ff == slpg_pkg::COUNT_MAX) ? mode_age_ff
                                                         : mode_age_ff + 16'd1;
   always_comb begin
      if (mode_age_ff == slpg_pkg::COUNT_MAX) begin
         phase_inc = phase_ff;
      end else if (phase_ff == slpg_pkg::RAMP_PERIOD_MS - 11'd1) begin
         phase_inc = '0;
      end else begin
         phase_inc = phase_ff + 11'd1;
      end
   end

   // Triangle level before scaling, and its product with the full level.
   always_comb begin
      if (phase_inc < slpg_pkg::RAMP_HALF_MS) begin
         tri_level = phase_inc[9:0];
      end else begin
         tri_level = 10'(slpg_pkg::RAMP_PERIOD_MS - phase_inc);
      end
   end
   assign ramp_product = {8'b0, tri_level} * {10'b0, max_brightness_ff};

   // One third of the full level for the connecting color.
   assign third_product = {8'b0, max_brightness_ff} * slpg_pkg::THIRD_RECIP;
   assign third = 8'(third_product >> slpg_pkg::THIRD_SHIFT);

   // Mode machine: next state and the color write of the transferred item.
   always_comb begin
      mode_in         = mode_ff;
      lit_in          = lit_ff;
      enable_level_in = enable_level_ff;
      since_toggle_in = since_toggle_ff;
      mode_age_in     = mode_age_ff;
      phase_in        = phase_ff;
      s1_in           = '0;
      s1_in.product   = ramp_product;
      en_set          = 1'b0;
      en_clr          = 1'b0;
      if (req_fire) begin
         if (req_data.kind == slpg_pkg::KIND_TICK) begin
            since_toggle_in = st_inc;
            mode_age_in     = age_inc;
            phase_in        = phase_inc;
            case (mode_ff)
               slpg_pkg::MODE_BOOT: begin
                  if (st_inc >= slpg_pkg::BOOT_HALF_MS) begin
                     since_toggle_in = '0;
                     lit_in          = !lit_ff;
                     s1_in.wr        = 1'b1;
                     if (!lit_ff) begin
                        s1_in.colour = {max_brightness_ff, max_brightness_ff,
                                        max_brightness_ff};
                        en_set       = 1'b1;
                     end else begin
                        en_clr = 1'b1;
                     end
                  end
               end
               slpg_pkg::MODE_ERROR: begin
                  if (st_inc >= slpg_pkg::ERROR_HALF_MS) begin
                     since_toggle_in = '0;
                     lit_in          = !lit_ff;
                     s1_in.wr        = 1'b1;
                     if (!lit_ff) begin
                        s1_in.colour = {max_brightness_ff, 16'b0};
                        en_set       = 1'b1;
                     end else begin
                        en_clr = 1'b1;
                     end
                  end
               end
               slpg_pkg::MODE_CONNECTED: begin
                  // The green period ends by falling back to off.
                  if (age_inc >= slpg_pkg::CONNECTED_MS) begin
                     mode_in         = slpg_pkg::MODE_OFF;
                     since_toggle_in = '0;
                     mode_age_in     = '0;
                     phase_in        = '0;
                     lit_in          = 1'b0;
                     s1_in.wr        = 1'b1;
                     en_clr          = 1'b1;
                  end
               end
               slpg_pkg::MODE_UPDATE: begin
                  if (st_inc >= slpg_pkg::RAMP_REFRESH_MS) begin
                     since_toggle_in = '0;
                     s1_in.wr        = 1'b1;
                     s1_in.ramp      = 1'b1;
                     en_set          = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end else if ((req_data.new_mode <= slpg_pkg::MODE_UPDATE) &&
                      (req_data.new_mode != mode_ff)) begin
            mode_in         = slpg_pkg::mode_type'(req_data.new_mode);
            since_toggle_in = '0;
            mode_age_in     = '0;
            phase_in        = '0;
            lit_in          = 1'b0;
            case (slpg_pkg::mode_type'(req_data.new_mode))
               slpg_pkg::MODE_OFF: begin
                  s1_in.wr = 1'b1;
                  en_clr   = 1'b1;
               end
               slpg_pkg::MODE_CONNECTING: begin
                  s1_in.wr     = 1'b1;
                  s1_in.colour = {max_brightness_ff, third, 8'b0};
                  en_set       = 1'b1;
               end
               slpg_pkg::MODE_DISCONNECTED: begin
                  s1_in.wr     = 1'b1;
                  s1_in.colour = {max_brightness_ff, 16'b0};
                  en_set       = 1'b1;
               end
               slpg_pkg::MODE_CONNECTED: begin
                  s1_in.wr     = 1'b1;
                  s1_in.colour = {8'b0, max_brightness_ff, 8'b0};
                  en_set       = 1'b1;
               end
               slpg_pkg::MODE_BOOT: begin
                  lit_in       = 1'b1;
                  s1_in.wr     = 1'b1;
                  s1_in.colour = {max_brightness_ff, max_brightness_ff, max_brightness_ff};
                  en_set       = 1'b1;
               end
               slpg_pkg::MODE_ERROR: begin
                  lit_in       = 1'b1;
                  s1_in.wr     = 1'b1;
                  s1_in.colour = {max_brightness_ff, 16'b0};
                  en_set       = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
      // The enable level only follows writes when an enable output is wired.
      if (enable_present_ff) begin
         if (en_set) begin
            enable_level_in = 1'b1;
         end
         if (en_clr) begin
            enable_level_in = 1'b0;
         end
      end
      s1_in.power_enable = enable_present_ff && enable_level_in;
   end

   // Output stage: divide the ramp product by 1000 and update the held color.
   assign quot_full  = {19'b0, s1_ff.product} * {18'b0, slpg_pkg::RAMP_RECIP};
   assign ramp_level = quot_full[slpg_pkg::RAMP_SHIFT +: 8];

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_data_in.power_enable = s1_ff.power_enable;
      rsp_data_in.write_strobe = s1_ff.wr;
      if (s1_ff.wr) begin
         if (s1_ff.ramp) begin
            {rsp_data_in.red, rsp_data_in.green, rsp_data_in.blue} = {16'b0, ramp_level};
         end else begin
            {rsp_data_in.red, rsp_data_in.green, rsp_data_in.blue} = s1_ff.colour;
         end
      end
   end

   // State, configuration and pipeline registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_brightness_ff <= slpg_pkg::MAX_BRIGHTNESS_RESET;
         enable_present_ff <= slpg_pkg::ENABLE_PRESENT_RESET;
         mode_ff           <= slpg_pkg::MODE_OFF;
         lit_ff            <= 1'b0;
         enable_level_ff   <= 1'b0;
         since_toggle_ff   <= '0;
         mode_age_ff       <= '0;
         phase_ff          <= '0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         rsp_data_ff       <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               slpg_pkg::CSR_MAX_BRIGHTNESS: max_brightness_ff <= csr_write_data;
               slpg_pkg::CSR_ENABLE_PRESENT: enable_present_ff <= csr_write_data[0];
               default: begin
               end
            endcase
         end
         mode_ff         <= mode_in;
         lit_ff          <= lit_in;
         enable_level_ff <= enable_level_in;
         since_toggle_ff <= since_toggle_in;
         mode_age_ff     <= mode_age_in;
         phase_ff        <= phase_in;
         if (s1_take) begin
            s1_valid_ff <= req_fire;
         end
         if (s2_take) begin
            rsp_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               rsp_data_ff <= rsp_data_in;
            end
         end
      end
      if (req_fire) begin
         s1_ff <= s1_in;
      end
   end

   // The connected period never outlives its timeout.
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == slpg_pkg::MODE_CONNECTED) |-> (mode_age_ff < slpg_pkg::CONNECTED_MS))
      else $error("connected mode outlived its timeout");

   // The ramp phase stays inside one period.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff < slpg_pkg::RAMP_PERIOD_MS)
      else $error("ramp phase out of range");

   // Only the blinking modes can be lit.
   assert property (@(posedge clock) disable iff (reset)
      lit_ff |-> ((mode_ff == slpg_pkg::MODE_BOOT) || (mode_ff == slpg_pkg::MODE_ERROR)))
      else $error("lit outside a blinking mode");

   // An item that writes no color leaves the held color as it was.
   assert property (@(posedge clock) disable iff (reset)
      (s2_take && s1_valid_ff && !s1_ff.wr) |=>
      ({rsp_data_ff.red, rsp_data_ff.green, rsp_data_ff.blue} ==
       $past({rsp_data_ff.red, rsp_data_ff.green, rsp_data_ff.blue})))
      else $error("color changed without a write");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the status LED pattern generator with a built-in color predictor.
`timescale 1ns / 100ps

module tb_top;

   // Request code seven has no mode and is ignored by the block.
   localparam logic [2:0] UNUSED_MODE_CODE = 3'd7;
   localparam int unsigned QUIET_LIMIT = 1000;
   localparam int unsigned RANDOM_PHASES = 4;
   localparam int unsigned ITEMS_PER_PHASE = 30;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   slpg_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   slpg_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 1'b0;
   logic              csr_index = 1'b0;
   logic [7:0]        csr_write_data = 8'd0;

   // Predicted LED state and register copies, at their reset values.
   slpg_pkg::mode_type led_mode = slpg_pkg::MODE_OFF;
   logic        led_lit = 1'b0;
   logic        led_enable = 1'b0;
   logic [15:0] led_since = 16'd0;
   logic [15:0] led_age = 16'd0;
   logic [23:0] led_color = 24'd0;
   logic        led_wrote = 1'b0;
   logic [7:0]  cfg_max = slpg_pkg::MAX_BRIGHTNESS_RESET;
   logic        cfg_enable_present = slpg_pkg::ENABLE_PRESENT_RESET;

   slpg_pkg::rsp_type expected_led[$];
   bit          idle_on = 1'b1;
   int unsigned failures = 0;
   int unsigned items_sent = 0;
   int unsigned results_checked = 0;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;

   status_led_pattern_generator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // A color write raises the power enable when one is wired.
   function automatic void paint(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
      if (cfg_enable_present) begin
         led_enable = 1'b1;
      end
      led_color = {r, g, b};
      led_wrote = 1'b1;
   endfunction

   // Writing black also drops the power enable and the lit flag.
   function automatic void paint_black();
      led_color = 24'd0;
      if (cfg_enable_present) begin
         led_enable = 1'b0;
      end
      led_lit = 1'b0;
      led_wrote = 1'b1;
   endfunction

   function automatic void switch_mode(input slpg_pkg::mode_type m);
      logic [7:0] mx;
      mx = cfg_max;
      led_mode = m;
      led_since = 16'd0;
      led_age = 16'd0;
      led_lit = 1'b0;
      case (m)
         slpg_pkg::MODE_OFF:          paint_black();
         slpg_pkg::MODE_CONNECTING:   paint(mx, mx / 8'd3, 8'd0);
         slpg_pkg::MODE_DISCONNECTED: paint(mx, 8'd0, 8'd0);
         slpg_pkg::MODE_CONNECTED:    paint(8'd0, mx, 8'd0);
         slpg_pkg::MODE_BOOT: begin
            led_lit = 1'b1;
            paint(mx, mx, mx);
         end
         slpg_pkg::MODE_ERROR: begin
            led_lit = 1'b1;
            paint(mx, 8'd0, 8'd0);
         end
         default: ;
      endcase
   endfunction

   function automatic void blink(input logic [15:0] half, input logic [7:0] r,
                                 input logic [7:0] g, input logic [7:0] b);
      if (led_since >= half) begin
         led_since = 16'd0;
         led_lit = ~led_lit;
         if (led_lit) begin
            paint(r, g, b);
         end else begin
            paint_black();
         end
      end
   endfunction

   // Advances the predicted LED state by one item and returns the levels it drives.
   function automatic slpg_pkg::rsp_type predict_led(input slpg_pkg::req_type item);
      slpg_pkg::rsp_type res;
      logic [7:0]  mx;
      int unsigned phase;
      int unsigned level;
      mx = cfg_max;
      led_wrote = 1'b0;
      if (item.kind == slpg_pkg::KIND_TICK) begin
         if (led_since != slpg_pkg::COUNT_MAX) begin
            led_since++;
         end
         if (led_age != slpg_pkg::COUNT_MAX) begin
            led_age++;
         end
         case (led_mode)
            slpg_pkg::MODE_BOOT:  blink(slpg_pkg::BOOT_HALF_MS, mx, mx, mx);
            slpg_pkg::MODE_ERROR: blink(slpg_pkg::ERROR_HALF_MS, mx, 8'd0, 8'd0);
            slpg_pkg::MODE_CONNECTED: begin
               if (led_age >= slpg_pkg::CONNECTED_MS) begin
                  switch_mode(slpg_pkg::MODE_OFF);
               end
            end
            slpg_pkg::MODE_UPDATE: begin
               // Triangle ramp, refreshed on its own interval; a saturated age freezes it.
               if (led_since >= slpg_pkg::RAMP_REFRESH_MS) begin
                  led_since = 16'd0;
                  phase = 32'(led_age) % 32'(slpg_pkg::RAMP_PERIOD_MS);
                  if (phase < 32'(slpg_pkg::RAMP_HALF_MS)) begin
                     level = phase * 32'(mx) / 32'(slpg_pkg::RAMP_HALF_MS);
                  end else begin
                     level = (32'(slpg_pkg::RAMP_PERIOD_MS) - phase) * 32'(mx) /
                             32'(slpg_pkg::RAMP_HALF_MS);
                  end
                  paint(8'd0, 8'd0, level[7:0]);
               end
            end
            default: ;
         endcase
      end else if (item.new_mode <= slpg_pkg::MODE_UPDATE && item.new_mode != led_mode) begin
         switch_mode(slpg_pkg::mode_type'(item.new_mode));
      end
      res.red = led_color[23:16];
      res.green = led_color[15:8];
      res.blue = led_color[7:0];
      res.power_enable = cfg_enable_present & led_enable;
      res.write_strobe = led_wrote;
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      failures++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s is %0h, expected %0h",
                                   results_checked, name, got, want));
      end
   endtask

   // Sends one item, with an optional idle burst first, and records its prediction.
   task automatic send_item(input logic kind, input logic [2:0] code);
      slpg_pkg::req_type item;
      int unsigned gap;
      item.kind = kind;
      item.new_mode = code;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_led.push_back(predict_led(item));
      items_sent++;
   endtask

   task automatic send_ticks(input int unsigned count);
      repeat (count) send_item(slpg_pkg::KIND_TICK, 3'd0);
   endtask

   task automatic request_mode(input logic [2:0] code);
      send_item(slpg_pkg::KIND_MODE, code);
   endtask

   // Waits until every expected result has arrived and the pipeline has emptied.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_led.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [7:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == slpg_pkg::CSR_MAX_BRIGHTNESS) begin
         cfg_max = value;
      end else begin
         cfg_enable_present = value[0];
      end
   endtask

   // Result side: checks every transfer and stalls in random bursts.
   always @(posedge clock) begin
      slpg_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_led.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               want = expected_led.pop_front();
               check_field("red", rsp_data.red, want.red);
               check_field("green", rsp_data.green, want.green);
               check_field("blue", rsp_data.blue, want.blue);
               check_field("power_enable", 8'(rsp_data.power_enable), 8'(want.power_enable));
               check_field("write_strobe", 8'(rsp_data.write_strobe), 8'(want.write_strobe));
               results_checked++;
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run if no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a transfer.", QUIET_LIMIT);
         $display("status_led_pattern_generator regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Every mode request, repeated and unused codes, and brightness extremes.
   task automatic test_mode_requests();
      send_ticks(1);
      request_mode(slpg_pkg::MODE_OFF);
      request_mode(UNUSED_MODE_CODE);
      request_mode(slpg_pkg::MODE_BOOT);
      request_mode(slpg_pkg::MODE_BOOT);
      request_mode(slpg_pkg::MODE_CONNECTING);
      request_mode(slpg_pkg::MODE_DISCONNECTED);
      request_mode(slpg_pkg::MODE_CONNECTED);
      request_mode(slpg_pkg::MODE_ERROR);
      request_mode(slpg_pkg::MODE_UPDATE);
      send_ticks(1);
      request_mode(slpg_pkg::MODE_OFF);
      write_csr(slpg_pkg::CSR_MAX_BRIGHTNESS, 8'd255);
      request_mode(slpg_pkg::MODE_CONNECTING);
      request_mode(UNUSED_MODE_CODE);
      send_ticks(1);
      // The held color must survive a brightness change until the next write.
      write_csr(slpg_pkg::CSR_MAX_BRIGHTNESS, 8'd0);
      send_ticks(1);
      request_mode(slpg_pkg::MODE_BOOT);
      request_mode(slpg_pkg::MODE_OFF);
   endtask

   // Error blink goes dark after one half period and lights again after the next.
   task automatic test_blink_timing();
      write_csr(slpg_pkg::CSR_MAX_BRIGHTNESS, 8'd200);
      request_mode(slpg_pkg::MODE_ERROR);
      send_ticks(410);
      request_mode(slpg_pkg::MODE_BOOT);
      send_ticks(10);
      request_mode(slpg_pkg::MODE_OFF);
   endtask

   // The first few ramp refreshes at full brightness.
   task automatic test_update_ramp();
      write_csr(slpg_pkg::CSR_MAX_BRIGHTNESS, 8'd255);
      request_mode(slpg_pkg::MODE_UPDATE);
      send_ticks(65);
      request_mode(slpg_pkg::MODE_OFF);
   endtask

   // Without a wired enable, writes leave the enable level alone and the output reads low.
   task automatic test_no_enable();
      write_csr(slpg_pkg::CSR_MAX_BRIGHTNESS, 8'd90);
      request_mode(slpg_pkg::MODE_DISCONNECTED);
      write_csr(slpg_pkg::CSR_ENABLE_PRESENT, 8'd0);
      request_mode(slpg_pkg::MODE_OFF);
      request_mode(slpg_pkg::MODE_BOOT);
      send_ticks(3);
      write_csr(slpg_pkg::CSR_ENABLE_PRESENT, 8'd1);
      send_ticks(2);
      request_mode(slpg_pkg::MODE_CONNECTING);
      request_mode(slpg_pkg::MODE_OFF);
   endtask

   // Random mode sequences with tick runs, over several register settings.
   task automatic test_random_sequences();
      int unsigned sent;
      int unsigned run;
      logic [7:0]  level;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       level = 8'd0;
            1:       level = 8'd255;
            2:       level = 8'd1;
            default: level = 8'($urandom_range(0, 255));
         endcase
         write_csr(slpg_pkg::CSR_MAX_BRIGHTNESS, level);
         write_csr(slpg_pkg::CSR_ENABLE_PRESENT,
                   (phase == 2) ? 8'd0 : 8'($urandom_range(0, 1)));
         // The final phase runs with no idling on either side.
         if (phase == RANDOM_PHASES - 1) begin
            idle_on = 1'b0;
         end
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            request_mode(3'($urandom_range(0, 7)));
            if ($urandom_range(0, 3) == 0) begin
               run = $urandom_range(20, 45);
            end else begin
               run = $urandom_range(0, 8);
            end
            send_ticks(run);
            sent += run + 1;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_mode_requests();
      test_blink_timing();
      test_update_ramp();
      test_no_enable();
      test_random_sequences();
      wait_idle();
      repeat (8) @(posedge clock);
      $display("Covered %0d items and %0d checked results: every mode request, error blink,",
               items_sent, results_checked);
      $display("ramp refresh, a missing enable output and random runs at several levels.");
      if (failures == 0) begin
         $display("status_led_pattern_generator regression: pass");
      end else begin
         $display("status_led_pattern_generator regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/slpg_pkg.sv
rtl/status_led_pattern_generator.sv
sim/tb_top.sv
